// File: rtl/qjtg_pkg.sv
// Package: shared constants, types and codes of the quintic trajectory generator.
package qjtg_pkg;

  localparam int unsigned JOINTS_MAX  = 7;
  localparam int unsigned ANGLE_W     = 32;
  localparam int unsigned PERIOD_W    = 10;
  localparam int unsigned MTIME_W     = 15;
  localparam int unsigned ELAPSED_W   = 16;
  localparam int unsigned FRAC_W      = 24;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [MTIME_W-1:0] MTIME_RESET = 15'd10000;

  localparam logic [CFG_IDX_W-1:0] REG_MOTION_TIME = 3'd0;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_POW,
    ST_BLEND,
    ST_OUT
  } ctrl_state_t;

  // power sequencer steps
  typedef enum logic [2:0] {
    PW_T2,
    PW_T3,
    PW_T4,
    PW_T5,
    PW_SUM
  } pow_step_t;

  function automatic angle_t target_reset(input int unsigned k);
    angle_t v;
    v = '0;
    case (k)
      1: v = -32'sd105414357;
      3: v = -32'sd421657428;
      6: v = 32'sd210828714;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/qjtg_if.sv
// Interfaces: valid/ready stream and configuration write channel.
interface qjtg_in_if;
  import qjtg_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [PERIOD_W-1:0]    period_ms;
  angle_t                 joint_measured [JOINTS_MAX];
  modport source (output valid, period_ms, joint_measured, input ready);
  modport sink   (input valid, period_ms, joint_measured, output ready);
endinterface

interface qjtg_out_if;
  import qjtg_pkg::*;
  logic   valid;
  logic   ready;
  angle_t joint_command [JOINTS_MAX];
  logic   motion_done;
  modport source (output valid, joint_command, motion_done, input ready);
  modport sink   (input valid, joint_command, motion_done, output ready);
endinterface

interface qjtg_cfg_if;
  import qjtg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/qjtg_serial_mul.sv
// Shift-and-add multiplier: one multiplier bit per cycle, signed multiplicand.
module qjtg_serial_mul #(
  parameter int unsigned A_W = 34,
  parameter int unsigned B_W = 25
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [A_W-1:0]     a,
  input  logic        [B_W-1:0]     b,
  output logic                      busy,
  output logic signed [A_W+B_W-1:0] prod
);
  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic signed [A_W+B_W-1:0] acc_r, acc_nxt;
  logic signed [A_W+B_W-1:0] mcand_r, mcand_nxt;
  logic        [B_W-1:0]     mplier_r, mplier_nxt;
  logic        [CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    if (start) begin
      acc_nxt    = '0;
      mcand_nxt  = (A_W+B_W)'(a);
      mplier_nxt = b;
      cnt_nxt    = CNT_W'(B_W);
    end else if (cnt_r != '0) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign busy = (cnt_r != '0) || start;
  assign prod = acc_r;
endmodule

// File: rtl/qjtg_serial_div.sv
// Restoring divider: one quotient bit per cycle, computes floor(elapsed*2^24/mtime).
module qjtg_serial_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [qjtg_pkg::ELAPSED_W-1:0]    num,
  input  logic [qjtg_pkg::MTIME_W-1:0]      den,
  output logic                              busy,
  output logic [qjtg_pkg::FRAC_W:0]         quot
);
  import qjtg_pkg::*;
  localparam int unsigned NUM_W = ELAPSED_W + FRAC_W;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]   dvd_r, dvd_nxt;
  logic [MTIME_W:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0]   q_r, q_nxt;
  logic [MTIME_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MTIME_W+1:0] trial;

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, dvd_r[NUM_W-1]} - {2'b00, den_r};
    if (start) begin
      dvd_nxt = {num, FRAC_W'(0)};
      rem_nxt = '0;
      q_nxt   = '0;
      den_nxt = den;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      dvd_nxt = dvd_r << 1;
      if (!trial[MTIME_W+1]) begin
        rem_nxt = trial[MTIME_W:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[MTIME_W-1:0], dvd_r[NUM_W-1]};
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign busy = (cnt_r != '0) || start;
  // elapsed < den here, so the quotient is below 2^24
  assign quot = q_r[FRAC_W:0];
endmodule

// File: rtl/quintic_joint_trajectory_generator_top.sv
// Top level: tick control, smoothstep evaluation and per-joint blending.
// Steps: serial divide, four serial power products and a sum step, then a serial blend per joint;
//   the result is registered and held until the output transfer.
// Flow: one tick at a time; input is taken again the cycle after the result
//   transfer. One bit-serial multiplier.
// Reset (synchronous, rst_n low): elapsed time and start flag cleared, control and configuration registers to defaults.
module quintic_joint_trajectory_generator_top #(
  parameter int unsigned JOINTS = qjtg_pkg::JOINTS_MAX
) (
  input  logic     clk,
  input  logic     rst_n,
  qjtg_in_if.sink  in_ch,
  qjtg_out_if.source out_ch,
  qjtg_cfg_if.sink cfg_ch
);
  import qjtg_pkg::*;
  localparam int unsigned JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int unsigned MA_W   = ANGLE_W + 2;
  localparam int unsigned MB_W   = FRAC_W + 1;
  localparam int unsigned P_W    = MA_W + MB_W;
  localparam logic [FRAC_W:0] ONE = {1'b1, FRAC_W'(0)};

  ctrl_state_t state_r, state_nxt;
  pow_step_t   pstep_r, pstep_nxt;

  logic [MTIME_W-1:0]   mtime_r;
  angle_t               target_r [JOINTS_MAX];
  angle_t               start_r  [JOINTS];
  angle_t               cmd_r    [JOINTS_MAX];
  logic                 started_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic                 done_r;
  logic [FRAC_W:0]      tau_r, t2_r, t4_r, s_r;
  logic signed [FRAC_W+5:0] sum_r;
  logic [JIDX_W-1:0]    jidx_r;
  logic                 out_valid_r;
  logic                 mul_started_r;

  logic [ELAPSED_W:0]   el_sum;
  logic [ELAPSED_W-1:0] el_new;
  logic                 div_start, div_busy;
  logic [FRAC_W:0]      div_q;
  logic                 mul_start, mul_busy;
  logic signed [MA_W-1:0] mul_a;
  logic [MB_W-1:0]      mul_b;
  logic signed [P_W-1:0] mul_p;
  logic [FRAC_W:0]      pw_res;
  logic signed [FRAC_W+5:0] s_sat_in;
  logic                 in_xfer, out_xfer, mul_fin;
  angle_t               st_sel, tg_sel;
  logic signed [P_W-1:0] rnd;
  angle_t               blended;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign el_sum = {1'b0, elapsed_r} + (ELAPSED_W+1)'(in_ch.period_ms);
  assign el_new = el_sum[ELAPSED_W] ? '1 : el_sum[ELAPSED_W-1:0];

  // divide starts on the transfer, so it takes the updated elapsed time
  qjtg_serial_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(el_new), .den(mtime_r),
    .busy(div_busy), .quot(div_q)
  );

  qjtg_serial_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .prod(mul_p)
  );

  assign st_sel  = start_r[jidx_r];
  assign tg_sel  = target_r[jidx_r];
  assign mul_fin = mul_started_r && !mul_busy;
  assign pw_res  = mul_p[2*FRAC_W:FRAC_W]; // power products stay below 2^49
  assign rnd     = mul_p + P_W'(signed'({1'b0, 1'b1, (FRAC_W-1)'(0)}));
  assign blended = st_sel + ANGLE_W'(rnd >>> FRAC_W);

  // multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_POW) begin
      unique case (pstep_r)
        PW_T2:   begin mul_a = MA_W'(tau_r); mul_b = tau_r; end
        PW_T3:   begin mul_a = MA_W'(t2_r);  mul_b = tau_r; end
        PW_T4:   begin mul_a = MA_W'(t2_r);  mul_b = t2_r;  end
        PW_T5:   begin mul_a = MA_W'(t4_r);  mul_b = tau_r; end
        default: begin mul_a = '0;           mul_b = '0;    end
      endcase
    end else begin
      mul_a = MA_W'(tg_sel) - MA_W'(st_sel);
      mul_b = s_r;
    end
  end

  assign s_sat_in = sum_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    pstep_nxt = pstep_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_DIV;
      ST_DIV:   if (!div_busy) begin
        state_nxt = ST_POW;
        pstep_nxt = PW_T2;
      end
      ST_POW: begin
        if (pstep_r == PW_SUM) state_nxt = ST_BLEND;
        else if (mul_fin) begin
          unique case (pstep_r)
            PW_T2:   pstep_nxt = PW_T3;
            PW_T3:   pstep_nxt = PW_T4;
            PW_T4:   pstep_nxt = PW_T5;
            default: pstep_nxt = PW_SUM;
          endcase
        end
      end
      ST_BLEND: if (mul_fin && (32'(jidx_r) == JOINTS - 1)) state_nxt = ST_OUT;
      ST_OUT:   if (out_xfer) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    div_start = 1'b0;
    mul_start = 1'b0;
    unique case (state_r)
      ST_IDLE:  div_start = 1'b0;
      ST_DIV:   div_start = 1'b0;
      ST_POW:   mul_start = (pstep_r != PW_SUM) && !mul_started_r;
      ST_BLEND: mul_start = !mul_started_r;
      default:  mul_start = 1'b0;
    endcase
    if (state_r == ST_IDLE && in_xfer) div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pstep_r       <= PW_T2;
      started_r     <= 1'b0;
      elapsed_r     <= '0;
      mtime_r       <= MTIME_RESET;
      out_valid_r   <= 1'b0;
      mul_started_r <= 1'b0;
      jidx_r        <= '0;
      for (int k = 0; k < JOINTS_MAX; k++) target_r[k] <= target_reset(k);
    end else begin
      state_r <= state_nxt;
      pstep_r <= pstep_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_MOTION_TIME) mtime_r <= cfg_ch.data[MTIME_W-1:0];
        else target_r[cfg_ch.index - 1'b1] <= cfg_ch.data;
      end
      if (in_xfer) begin
        started_r <= 1'b1;
        elapsed_r <= el_new;
      end
      if (mul_start) mul_started_r <= 1'b1;
      else if (mul_fin) mul_started_r <= 1'b0;
      if (state_r == ST_POW && pstep_r == PW_SUM) jidx_r <= '0;
      else if (state_r == ST_BLEND && mul_fin && (32'(jidx_r) != JOINTS - 1))
        jidx_r <= jidx_r + 1'b1;
      if (state_r == ST_BLEND && state_nxt == ST_OUT) out_valid_r <= 1'b1;
      else if (out_xfer) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer && !started_r) begin
      for (int k = 0; k < JOINTS; k++) start_r[k] <= in_ch.joint_measured[k];
    end
    if (state_r == ST_DIV && !div_busy) begin
      done_r <= (elapsed_r >= ELAPSED_W'(mtime_r));
      tau_r  <= (elapsed_r >= ELAPSED_W'(mtime_r)) ? ONE : div_q;
      sum_r  <= '0;
    end
    if (state_r == ST_POW && mul_fin) begin
      unique case (pstep_r)
        PW_T2: t2_r <= pw_res;
        PW_T3: sum_r <= sum_r + (FRAC_W+6)'(pw_res) * (FRAC_W+6)'(10);
        PW_T4: begin
          t4_r  <= pw_res;
          sum_r <= sum_r - (FRAC_W+6)'(pw_res) * (FRAC_W+6)'(15);
        end
        PW_T5: sum_r <= sum_r + (FRAC_W+6)'(pw_res) * (FRAC_W+6)'(6);
        default: sum_r <= sum_r;
      endcase
    end
    if (state_r == ST_POW && pstep_r == PW_SUM) begin
      if (s_sat_in < 0) s_r <= '0;
      else if (s_sat_in > (FRAC_W+6)'(ONE)) s_r <= ONE;
      else s_r <= s_sat_in[FRAC_W:0];
      for (int k = 0; k < JOINTS_MAX; k++) cmd_r[k] <= '0;
    end
    if (state_r == ST_BLEND && mul_fin) cmd_r[jidx_r] <= blended;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.joint_command = cmd_r;
  assign out_ch.motion_done   = done_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  a_started: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> started_r) else $error("start flag not set after transfer");
  a_s_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BLEND) |-> (s_r <= ONE)) else $error("s out of range");
  a_done_tau: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.motion_done) |-> (s_r == ONE)) else $error("done without s=1");
`endif
endmodule

// File: tb/sv/testbench.sv
// Testbench: random and directed ticks into the quintic trajectory generator, checked against a predictor.
module testbench;
  import qjtg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NJ = JOINTS_MAX;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET0 = 3'd1;

  typedef struct packed {
    logic [PERIOD_W-1:0]          period;
    logic [NJ-1:0][ANGLE_W-1:0]   meas;
  } tick_t;

  typedef struct packed {
    logic [NJ-1:0][ANGLE_W-1:0]   cmd;
    logic                         done;
  } command_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  qjtg_in_if  in_ch ();
  qjtg_out_if out_ch ();
  qjtg_cfg_if cfg_ch ();

  quintic_joint_trajectory_generator_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [MTIME_W-1:0]   mtime;
  logic [ANGLE_W-1:0]   target [NJ];
  logic                 started;
  logic [ELAPSED_W-1:0] elapsed;
  logic [ANGLE_W-1:0]   start_pos [NJ];

  tick_t    pending_ticks [$];
  command_t expected_cmds [$];
  int       errors = 0;
  int       results_seen = 0;
  int       cycles = 0;
  bit       no_idle = 1'b0;
  bit       hold_started = 1'b0;
  int       hold_count = 0;

  function automatic command_t predict_command(tick_t t);
    command_t r;
    longint unsigned tau, t2, t3, t4, t5, sum;
    longint s, st, diff, delta, el;
    if (!started) begin
      started = 1'b1;
      for (int k = 0; k < NJ; k++) start_pos[k] = t.meas[k];
    end
    el = longint'(elapsed) + longint'(t.period);
    if (el > 65535) el = 65535;
    elapsed = el[ELAPSED_W-1:0];
    r.done = (elapsed >= {1'b0, mtime});
    if (r.done) tau = 64'd1 << FRAC_W;
    else tau = (longint'(elapsed) << FRAC_W) / longint'(mtime);
    t2 = (tau * tau) >> FRAC_W;
    t3 = (t2 * tau) >> FRAC_W;
    t4 = (t2 * t2) >> FRAC_W;
    t5 = (t4 * tau) >> FRAC_W;
    s = 10 * longint'(t3) - 15 * longint'(t4) + 6 * longint'(t5);
    if (s < 0) s = 0;
    if (s > (longint'(1) << FRAC_W)) s = longint'(1) << FRAC_W;
    for (int k = 0; k < NJ; k++) begin
      st = longint'(signed'(start_pos[k]));
      diff = longint'(signed'(target[k])) - st;
      delta = (s * diff + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
      sum = st + delta;
      r.cmd[k] = sum[ANGLE_W-1:0];
    end
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.period_ms <= '0;
      for (int k = 0; k < NJ; k++) in_ch.joint_measured[k] <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        tick_t t;
        t.period = in_ch.period_ms;
        for (int k = 0; k < NJ; k++) t.meas[k] = in_ch.joint_measured[k];
        expected_cmds.push_back(predict_command(t));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ticks.size() > 0 && (no_idle || $urandom_range(99) >= 35)) begin
          tick_t t;
          t = pending_ticks.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.period_ms <= t.period;
          for (int k = 0; k < NJ; k++) in_ch.joint_measured[k] <= t.meas[k];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off once the run is under way
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (!hold_started && results_seen == 40) begin
      hold_started <= 1'b1;
      hold_count <= 1500;
      out_ch.ready <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= 35);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected result transfer", $time);
        errors++;
      end else begin
        command_t e;
        e = expected_cmds.pop_front();
        for (int k = 0; k < NJ; k++)
          if (out_ch.joint_command[k] !== e.cmd[k]) begin
            $display("%0t: joint %0d command expected %h actual %h", $time, k,
                     e.cmd[k], out_ch.joint_command[k]);
            errors++;
          end
        if (out_ch.motion_done !== e.done) begin
          $display("%0t: motion_done expected %b actual %b", $time, e.done,
                   out_ch.motion_done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("quintic_joint_trajectory_generator_top regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_MOTION_TIME) mtime = val[MTIME_W-1:0];
    else target[idx - 1] = val;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_ticks.size() > 0 || expected_cmds.size() > 0 || in_ch.valid);
  endtask

  task automatic push_tick(int per, bit extreme);
    tick_t t;
    t.period = per[PERIOD_W-1:0];
    for (int k = 0; k < NJ; k++)
      t.meas[k] = extreme ? (k[0] ? 32'h8000_0000 : 32'h7fff_ffff) : $urandom;
    pending_ticks.push_back(t);
  endtask

  task automatic random_targets(bit extreme);
    for (int k = 0; k < NJ; k++)
      write_reg(REG_TARGET0 + k[2:0],
                extreme ? (k[0] ? 32'h7fff_ffff : 32'h8000_0000) : $urandom);
  endtask

  task automatic random_ticks(int n, int max_per);
    for (int i = 0; i < n; i++)
      push_tick(($urandom_range(19) == 0) ? $urandom_range(1023) : $urandom_range(max_per), 0);
  endtask

  initial begin
    mtime = MTIME_RESET;
    for (int k = 0; k < NJ; k++) target[k] = target_reset(k);
    started = 1'b0;
    elapsed = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset targets, extreme start angles, zero and small periods
    push_tick(0, 1);
    push_tick(0, 0);
    push_tick(1, 0);
    for (int i = 0; i < 6; i++) push_tick(500 + i, 0);
    wait_drained();
    write_reg(REG_MOTION_TIME, 32'hffff_8000 | 32'd30000);
    random_targets(1);
    for (int i = 0; i < 8; i++) push_tick(i * 7, 0);
    wait_drained();

    // random phases; elapsed only grows, so long motion times come first
    write_reg(REG_MOTION_TIME, 32'd32767);
    random_targets(0);
    random_ticks(150, 40);
    wait_drained();
    write_reg(REG_MOTION_TIME, $urandom_range(32767, 20000));
    random_targets(0);
    no_idle = 1'b1;
    random_ticks(100, 40);
    wait_drained();
    no_idle = 1'b0;
    write_reg(REG_MOTION_TIME, 32'd1);
    random_targets(0);
    random_ticks(100, 1023);
    wait_drained();
    // zero motion time, then full periods to saturate elapsed time
    write_reg(REG_MOTION_TIME, 32'd0);
    random_targets(1);
    for (int i = 0; i < 70; i++) push_tick(1023, 0);
    wait_drained();
    write_reg(REG_MOTION_TIME, $urandom_range(32767));
    random_targets(0);
    random_ticks(80, 1023);
    wait_drained();

    repeat (500) @(posedge clk);
    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("quintic_joint_trajectory_generator_top regression: pass");
    end else begin
      $display("quintic_joint_trajectory_generator_top regression: fail");
    end
    $finish;
  end
endmodule
